// ===== rtl/lgs_pkg.sv =====
// Shared types and constants for the life grid generation step block.
package lgs_pkg;

   localparam int INDEX_WIDTH = 8;
   localparam int INDEX_SPAN  = 1 << INDEX_WIDTH;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;

   localparam logic [3:0] BIRTH_COUNT  = 4'd3;
   localparam logic [3:0] SURVIVE_LOW  = 4'd2;
   localparam logic [3:0] SURVIVE_HIGH = 4'd3;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic write;
      logic advance;
      logic value;
   } cell_cmd_type;

endpackage

// ===== rtl/lgs_cell.sv =====
// One grid cell: its state bit, neighbor count, B3/S23 rule and address match.
module lgs_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lgs_pkg::cell_cmd_type             cmd,
   input  logic [lgs_pkg::INDEX_WIDTH-1:0]   index,
   input  logic [7:0]                        neighbors,
   output logic                              state,
   output logic                              hit
);
   import lgs_pkg::*;

   localparam bit ADDRESSABLE = CELL_INDEX < INDEX_SPAN;
   localparam logic [INDEX_WIDTH-1:0] CELL_ADDR = INDEX_WIDTH'(CELL_INDEX % INDEX_SPAN);

   logic       state_ff;
   logic       state_in;
   logic       match;
   logic [3:0] count;
   logic       rule_next;

   assign match = ADDRESSABLE && (index == CELL_ADDR);
   assign count = 4'($countones(neighbors));

   always_comb begin
      if (state_ff) begin
         rule_next = (count >= SURVIVE_LOW) && (count <= SURVIVE_HIGH);
      end else begin
         rule_next = (count == BIRTH_COUNT);
      end
   end

   always_comb begin
      priority if (cmd.advance) begin
         state_in = rule_next;
      end else if (cmd.write && match) begin
         state_in = cmd.value;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;
   assign hit   = match & state_ff;

endmodule

// ===== rtl/life_grid_generation_step.sv =====
// Top level: grid of life cells, command decode and read-out path.
// A write or an advance gives its result in the cycle after the item is accepted;
// a read registers the row reduction, then the column reduction, before its result.
// The controller holds one item until its result is taken, so no new item is
// accepted before the response handshake completes.
// An advance updates every cell at once from its neighbors' registers.
// Synchronous active-high reset clears every cell to dead and idles the controller.
module life_grid_generation_step #(
   parameter int GRID_SIDE = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [lgs_pkg::INDEX_WIDTH-1:0] req_cell_index,
   input  logic                            req_cell_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_cell_state
);
   import lgs_pkg::*;

   localparam int CELLS    = GRID_SIDE * GRID_SIDE;
   localparam int PAD_SIDE = GRID_SIDE + 2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic                   rsp_state_ff, rsp_state_in;
   logic [GRID_SIDE-1:0]   row_hit_ff, row_hit_in;
   logic [GRID_SIDE-1:0]   row_hit;
   logic [CELLS-1:0]       grid;
   logic [CELLS-1:0]       cell_hit;
   logic [PAD_SIDE*PAD_SIDE-1:0] pad;
   logic                   accept;
   cell_cmd_type           cmd;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_cell_state = rsp_state_ff;

   assign cmd.write   = accept && (req_operation == OP_WRITE);
   assign cmd.advance = accept && (req_operation == OP_ADVANCE);
   assign cmd.value   = req_cell_value;

   // The grid surrounded by a ring of dead cells, so every cell sees eight neighbors.
   for (genvar pr = 0; pr < PAD_SIDE; pr++) begin : g_pad_row
      for (genvar pc = 0; pc < PAD_SIDE; pc++) begin : g_pad_col
         if (pr == 0 || pc == 0 || pr == PAD_SIDE - 1 || pc == PAD_SIDE - 1) begin : g_edge
            assign pad[pr*PAD_SIDE+pc] = 1'b0;
         end else begin : g_inner
            assign pad[pr*PAD_SIDE+pc] = grid[(pr-1)*GRID_SIDE+(pc-1)];
         end
      end
   end

   for (genvar r = 0; r < GRID_SIDE; r++) begin : g_row
      for (genvar c = 0; c < GRID_SIDE; c++) begin : g_col
         localparam int P = (r + 1) * PAD_SIDE + (c + 1);
         logic [7:0] nbr;
         assign nbr = {pad[P-PAD_SIDE-1], pad[P-PAD_SIDE], pad[P-PAD_SIDE+1],
                       pad[P-1], pad[P+1],
                       pad[P+PAD_SIDE-1], pad[P+PAD_SIDE], pad[P+PAD_SIDE+1]};
         lgs_cell #(
            .CELL_INDEX(r * GRID_SIDE + c)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .index     (req_cell_index),
            .neighbors (nbr),
            .state     (grid[r*GRID_SIDE+c]),
            .hit       (cell_hit[r*GRID_SIDE+c])
         );
      end
      assign row_hit[r] = |cell_hit[r*GRID_SIDE +: GRID_SIDE];
   end

   always_comb begin
      state_in     = state_ff;
      rsp_state_in = rsp_state_ff;
      row_hit_in   = row_hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_hit_in = row_hit;
               if (req_operation == OP_READ) begin
                  state_in = ST_READ;
               end else begin
                  rsp_state_in = 1'b0;
                  state_in     = ST_RESP;
               end
            end
         end
         ST_READ: begin
            rsp_state_in = |row_hit_ff;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_state_ff <= rsp_state_in;
      row_hit_ff   <= row_hit_in;
   end

   // Only one cell can match an index, so at most one row reports a hit.
   a_single_row_hit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $onehot0(row_hit_ff))
      else $error("more than one row matched a read index");

   a_one_item_in_flight : assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("new item taken while one is in flight");

   a_advance_gives_zero : assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_ADVANCE) |=> (rsp_valid && !rsp_cell_state))
      else $error("advance item did not give a zero result next cycle");

endmodule
